/* sv/sbblit_pkg.sv */
// Shared types and constants for the scaled bitmap span blitter.
// No dependencies; every other file of the block imports this package.
package sbblit_pkg;

   localparam int ADDR_W     = 21;
   localparam int COLOR_W    = 8;
   localparam int SCALE_W    = 4;
   localparam int OX_W       = 9;
   localparam int OY_W       = 8;
   localparam int IW_W       = 9;
   localparam int IH_W       = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Screen position of a span's top-left byte, wide enough for any
   // register setting: 511 + 15 * 511 and 255 + 15 * 255.
   localparam int X0_W = 13;
   localparam int Y0_W = 12;

   localparam logic [ADDR_W-1:0] FB_BASE = 21'h0A_0000;

   localparam int DEF_SCREEN_WIDTH = 320;
   localparam int DEF_MAX_SCALE    = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X     = 3'd0,
      CSR_ORIGIN_Y     = 3'd1,
      CSR_IMAGE_WIDTH  = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_SCALE_FACTOR = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [OX_W-1:0]    origin_x;
      logic [OY_W-1:0]    origin_y;
      logic [IW_W-1:0]    image_width;
      logic [IH_W-1:0]    image_height;
      logic [SCALE_W-1:0] scale_factor;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC_POS,
      ST_CALC_ADDR,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_pos;
      logic calc_addr;
      logic next_span;
   } dp_cmd_type;

   typedef struct packed {
      logic scale_zero;
      logic span_last;
   } dp_sts_type;

endpackage

/* sv/scaled_bitmap_span_blitter.sv */
// Scaled bitmap span blitter, top level. Depends on sbblit_pkg, sbblit_regs,
// sbblit_ctrl and sbblit_dp.
// After a pixel is taken in ST_IDLE, the sequencer passes ST_CALC_POS and
// ST_CALC_ADDR, then offers the spans in ST_EMIT (none for a zero scale); the span
// sequencer handles one pixel at a time, one span per cycle while rsp_stall is low.
// Reset (synchronous, active high) returns the registers to their defaults and
// clears the position counters; no pass over storage is needed.
module scaled_bitmap_span_blitter #(
   parameter int SCREEN_WIDTH = sbblit_pkg::DEF_SCREEN_WIDTH,
   parameter int MAX_SCALE    = sbblit_pkg::DEF_MAX_SCALE
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [sbblit_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbblit_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // pixel transactions
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sbblit_pkg::COLOR_W-1:0]      req_pixel_color,
   // span transactions
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbblit_pkg::ADDR_W-1:0]       rsp_span_address,
   output logic [sbblit_pkg::SCALE_W-1:0]      rsp_span_length,
   output logic [sbblit_pkg::COLOR_W-1:0]      rsp_span_color,
   output logic                                rsp_last_span,
   output logic                                rsp_image_done
);
   import sbblit_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // register file: hold origin, image size and scale between writes
   sbblit_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: take a pixel, run the two address steps, then drain its spans
   sbblit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: advance the counters and step the address down one screen row
   // per span; the span fields are driven straight from its registers
   sbblit_dp #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .MAX_SCALE    (MAX_SCALE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_pixel_color  (req_pixel_color),
      .rsp_span_address (rsp_span_address),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_color   (rsp_span_color),
      .rsp_last_span    (rsp_last_span),
      .rsp_image_done   (rsp_image_done)
   );

endmodule

/* sv/sbblit_regs.sv */
// Configuration register file of the span blitter.
// Depends on sbblit_pkg.
module sbblit_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sbblit_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbblit_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sbblit_pkg::cfg_type                 cfg
);
   import sbblit_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[OX_W-1:0];
            CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[OY_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[IW_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[IH_W-1:0];
            CSR_SCALE_FACTOR: cfg_in.scale_factor = csr_wdata[SCALE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.image_width  <= IW_W'(1);
         cfg_ff.image_height <= IH_W'(1);
         cfg_ff.scale_factor <= SCALE_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sbblit_ctrl.sv */
// Sequencer of the span blitter: accept a pixel, work out its start
// address, then hand out one span per screen row. Depends on sbblit_pkg.
module sbblit_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sbblit_pkg::dp_cmd_type  cmd,
   input  sbblit_pkg::dp_sts_type  sts
);
   import sbblit_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC_POS;
            end
         end
         ST_CALC_POS: begin
            cmd.calc_pos = 1'b1;
            state_in     = ST_CALC_ADDR;
         end
         ST_CALC_ADDR: begin
            cmd.calc_addr = 1'b1;
            // an empty square yields no span at all
            state_in = sts.scale_zero ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.span_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_span = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* sv/sbblit_dp.sv */
// Datapath of the span blitter: pixel counters, position multiplies,
// frame buffer address and the span output register. Depends on sbblit_pkg.
module sbblit_dp #(
   parameter int SCREEN_WIDTH = sbblit_pkg::DEF_SCREEN_WIDTH,
   parameter int MAX_SCALE    = sbblit_pkg::DEF_MAX_SCALE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbblit_pkg::cfg_type                 cfg,
   input  sbblit_pkg::dp_cmd_type              cmd,
   output sbblit_pkg::dp_sts_type              sts,
   input  logic [sbblit_pkg::COLOR_W-1:0]      req_pixel_color,
   output logic [sbblit_pkg::ADDR_W-1:0]       rsp_span_address,
   output logic [sbblit_pkg::SCALE_W-1:0]      rsp_span_length,
   output logic [sbblit_pkg::COLOR_W-1:0]      rsp_span_color,
   output logic                                rsp_last_span,
   output logic                                rsp_image_done
);
   import sbblit_pkg::*;

   localparam int SW_W   = $clog2(SCREEN_WIDTH + 1);
   localparam int PROD_W = SW_W + Y0_W;
   localparam logic [SW_W-1:0]   SW_CONST  = SW_W'(SCREEN_WIDTH);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);

   // position counters (control state)
   logic [IW_W-1:0] column_count_ff, column_count_in;
   logic [IH_W-1:0] row_count_ff, row_count_in;

   // per pixel snapshot
   logic [COLOR_W-1:0] color_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [IW_W-1:0]    col_ff;
   logic [IH_W-1:0]    row_ff;
   logic               img_end_ff;

   logic [X0_W-1:0]    x0_ff;
   logic [Y0_W-1:0]    y0_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [SCALE_W-1:0] span_idx_ff;

   logic [SCALE_W-1:0] scale_eff;
   logic               row_end;
   logic               img_end;
   logic [PROD_W-1:0]  row_offset;

   always_comb begin
      if (32'(cfg.scale_factor) > MAX_SCALE) begin
         scale_eff = SCALE_W'(MAX_SCALE);
      end else begin
         scale_eff = cfg.scale_factor;
      end
      // a width or height of zero behaves as one
      row_end = ({1'b0, column_count_ff} + (IW_W + 1)'(1)) >= {1'b0, cfg.image_width};
      img_end = row_end &&
                (({1'b0, row_count_ff} + (IH_W + 1)'(1)) >= {1'b0, cfg.image_height});

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (cmd.load) begin
         if (row_end) begin
            column_count_in = '0;
            row_count_in    = img_end ? '0 : row_count_ff + IH_W'(1);
         end else begin
            column_count_in = column_count_ff + IW_W'(1);
         end
      end
      row_offset = SW_CONST * PROD_W'(y0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         color_ff   <= req_pixel_color;
         scale_ff   <= scale_eff;
         col_ff     <= column_count_ff;
         row_ff     <= row_count_ff;
         img_end_ff <= img_end;
      end
      if (cmd.calc_pos) begin
         x0_ff <= X0_W'(cfg.origin_x) + X0_W'(scale_ff) * X0_W'(col_ff);
         y0_ff <= Y0_W'(cfg.origin_y) + Y0_W'(scale_ff) * Y0_W'(row_ff);
      end
      if (cmd.calc_addr) begin
         addr_ff     <= FB_BASE + ADDR_W'(row_offset) + ADDR_W'(x0_ff);
         span_idx_ff <= '0;
      end else if (cmd.next_span) begin
         addr_ff     <= addr_ff + ROW_STEP;
         span_idx_ff <= span_idx_ff + SCALE_W'(1);
      end
   end

   always_comb begin
      sts.scale_zero = (scale_ff == '0);
      sts.span_last  = ((span_idx_ff + SCALE_W'(1)) == scale_ff);
   end

   assign rsp_span_address = addr_ff;
   assign rsp_span_length  = scale_ff;
   assign rsp_span_color   = color_ff;
   assign rsp_last_span    = sts.span_last;
   assign rsp_image_done   = img_end_ff;

endmodule
